// File: rtl/core/djc_pkg.sv
// shared constants, register codes and item types for the depth to jet color core
`default_nettype none

package djc_pkg;

   // field widths
   localparam int SCALE_FRAC_BITS = 16;
   localparam int RAW_W           = 16;
   localparam int SCALE_W         = 24;
   localparam int MM_W            = 16;
   localparam int COLOR_W         = 8;
   localparam int LEVEL_BITS      = 8;

   // datapath widths
   localparam int PROD_W  = RAW_W + SCALE_W;
   localparam int NUM_W   = PROD_W + LEVEL_BITS;
   localparam int LEVEL_W = NUM_W - SCALE_FRAC_BITS;

   // queue between front and back
   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_AW    = 3;
   localparam int QUEUE_CW    = QUEUE_AW + 1;
   localparam int FRONT_STAGES = 3;
   localparam int BUSY_W      = 2;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEPTH_SCALE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEPTH_MIN_MM = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEPTH_MAX_MM = 2'd2;

   localparam logic [SCALE_W-1:0] DEPTH_SCALE_RESET  = 24'd65536;
   localparam logic [MM_W-1:0]    DEPTH_MIN_RESET    = 16'd0;
   localparam logic [MM_W-1:0]    DEPTH_MAX_RESET    = 16'd10000;
   localparam logic [MM_W-1:0]    FALLBACK_SPAN_MM   = 16'd1000;

   // settings the front part needs
   typedef struct packed {
      logic [SCALE_W-1:0] depth_scale;
      logic [MM_W-1:0]    depth_min_mm;
   } front_cfg_type;

   // classified request handed from front to back
   typedef struct packed {
      logic               invalid;
      logic               below;
      logic [LEVEL_W-1:0] level;
   } item_type;

endpackage

`default_nettype wire

// File: rtl/core/djc_front.sv
// front part: scales the raw depth, offsets it and classifies the request
`default_nettype none

module djc_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire logic [djc_pkg::RAW_W-1:0] depth_raw,
   input  wire djc_pkg::front_cfg_type cfg,
   output logic                        push,
   output djc_pkg::item_type           push_item,
   output logic [djc_pkg::BUSY_W-1:0]  busy
);
   import djc_pkg::*;

   logic                  a_valid_ff;
   logic                  a_invalid_ff;
   logic [PROD_W-1:0]     a_prod_ff;
   logic                  b_valid_ff;
   logic                  b_invalid_ff;
   logic                  b_below_ff;
   logic [PROD_W-1:0]     b_diff_ff;
   logic                  c_valid_ff;
   item_type              c_item_ff;

   logic [PROD_W-1:0]     lo_fixed;
   logic [PROD_W-1:0]     a_prod_in;
   logic [PROD_W-1:0]     b_diff_in;
   logic                  b_below_in;
   logic [NUM_W-1:0]      num;
   item_type              c_item_in;

   // depth offset in the same fixed point as the product
   assign lo_fixed = {{(PROD_W-MM_W-SCALE_FRAC_BITS){1'b0}}, cfg.depth_min_mm,
                      {SCALE_FRAC_BITS{1'b0}}};

   // stage a: raw times scale
   assign a_prod_in = PROD_W'({{SCALE_W{1'b0}}, depth_raw} * {{RAW_W{1'b0}}, cfg.depth_scale});

   // stage b: offset by the minimum
   assign b_below_in = (a_prod_ff <= lo_fixed);
   assign b_diff_in  = a_prod_ff - lo_fixed;

   // stage c: times 255, drop the fraction
   always_comb begin
      num = {b_diff_ff, {LEVEL_BITS{1'b0}}} - {{LEVEL_BITS{1'b0}}, b_diff_ff};
      c_item_in.invalid = b_invalid_ff;
      c_item_in.below   = b_below_ff;
      c_item_in.level   = num[NUM_W-1:SCALE_FRAC_BITS];
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      a_prod_ff    <= a_prod_in;
      a_invalid_ff <= (depth_raw == '0);
      b_diff_ff    <= b_diff_in;
      b_below_ff   <= b_below_in;
      b_invalid_ff <= a_invalid_ff;
      c_item_ff    <= c_item_in;
   end

   assign push      = c_valid_ff;
   assign push_item = c_item_ff;
   assign busy      = BUSY_W'({1'b0, a_valid_ff} + {1'b0, b_valid_ff} + {1'b0, c_valid_ff});

endmodule

`default_nettype wire

// File: rtl/core/djc_queue.sv
// short request queue between the front and back parts
`default_nettype none

module djc_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire djc_pkg::item_type        push_item,
   input  wire logic                     pop,
   output djc_pkg::item_type             head_item,
   output logic                          head_valid,
   output logic [djc_pkg::QUEUE_CW-1:0]  count
);
   import djc_pkg::*;

   item_type              mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff;
   logic [QUEUE_AW-1:0]   rd_ptr_ff;
   logic [QUEUE_CW-1:0]   count_ff;
   logic [QUEUE_CW-1:0]   count_in;

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CW'(1);
      end else if (!push && pop) begin
         count_in = count_ff - QUEUE_CW'(1);
      end
   end

   // pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(1);
         end
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item  = mem[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign count      = count_ff;

endmodule

`default_nettype wire

// File: rtl/core/djc_back.sv
// back part: pipelined level divider, jet color map and response register
`default_nettype none

module djc_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [djc_pkg::MM_W-1:0]    span,
   input  wire logic                        head_valid,
   input  wire djc_pkg::item_type           head_item,
   output logic                             pop,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [djc_pkg::COLOR_W-1:0]      rsp_red,
   output logic [djc_pkg::COLOR_W-1:0]      rsp_green,
   output logic [djc_pkg::COLOR_W-1:0]      rsp_blue
);
   import djc_pkg::*;

   localparam int STEPS = LEVEL_BITS;

   logic                  advance;

   logic                  stg_valid_ff   [STEPS+1];
   logic                  stg_invalid_ff [STEPS+1];
   logic                  stg_below_ff   [STEPS+1];
   logic                  stg_sat_ff     [STEPS+1];
   logic [LEVEL_W-1:0]    stg_rem_ff     [STEPS+1];
   logic [LEVEL_BITS-1:0] stg_quo_ff     [STEPS+1];

   logic [LEVEL_W-1:0]    stg_rem_in     [STEPS];
   logic [LEVEL_BITS-1:0] stg_quo_in     [STEPS];

   logic [LEVEL_W-1:0]    span_wide;
   logic                  sat_in;
   logic [LEVEL_BITS-1:0] level_v;

   logic                  rsp_valid_ff;
   logic [COLOR_W-1:0]    red_ff;
   logic [COLOR_W-1:0]    green_ff;
   logic [COLOR_W-1:0]    blue_ff;
   logic [COLOR_W-1:0]    red_in;
   logic [COLOR_W-1:0]    green_in;
   logic [COLOR_W-1:0]    blue_in;

   // whole pipeline moves unless the response is held
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop     = advance && head_valid;

   // quotient would pass 255
   assign span_wide = LEVEL_W'(span);
   assign sat_in    = (head_item.level >= (span_wide << LEVEL_BITS));

   // entry stage from the queue
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff[0] <= 1'b0;
      end else if (advance) begin
         stg_valid_ff[0] <= head_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stg_invalid_ff[0] <= head_item.invalid;
         stg_below_ff[0]   <= head_item.below;
         stg_sat_ff[0]     <= sat_in;
         stg_rem_ff[0]     <= head_item.level;
         stg_quo_ff[0]     <= '0;
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar i = 0; i < STEPS; i++) begin : g_div
      localparam int BIT = STEPS - 1 - i;
      logic [LEVEL_W-1:0] trial;
      logic               fits;

      always_comb begin
         trial         = span_wide << BIT;
         fits          = (stg_rem_ff[i] >= trial);
         stg_rem_in[i] = fits ? (stg_rem_ff[i] - trial) : stg_rem_ff[i];
         stg_quo_in[i] = stg_quo_ff[i];
         stg_quo_in[i][BIT] = fits;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stg_valid_ff[i+1] <= 1'b0;
         end else if (advance) begin
            stg_valid_ff[i+1] <= stg_valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            stg_invalid_ff[i+1] <= stg_invalid_ff[i];
            stg_below_ff[i+1]   <= stg_below_ff[i];
            stg_sat_ff[i+1]     <= stg_sat_ff[i];
            stg_rem_ff[i+1]     <= stg_rem_in[i];
            stg_quo_ff[i+1]     <= stg_quo_in[i];
         end
      end
   end

   // level after clamping
   always_comb begin
      if (stg_below_ff[STEPS]) begin
         level_v = '0;
      end else if (stg_sat_ff[STEPS]) begin
         level_v = '1;
      end else begin
         level_v = stg_quo_ff[STEPS];
      end
   end

   // five segment jet map
   always_comb begin
      logic [10:0] v4;
      logic [10:0] r;
      logic [10:0] g;
      logic [10:0] b;
      v4 = {1'b0, level_v, 2'b00};
      r  = '0;
      g  = '0;
      b  = '0;
      if (level_v <= 8'd31) begin
         b = 11'd127 + v4;
      end else if (level_v <= 8'd95) begin
         g = v4 - 11'd128;
         b = 11'd255;
      end else if (level_v <= 8'd159) begin
         r = v4 - 11'd383;
         g = 11'd255;
         b = 11'd637 - v4;
      end else if (level_v <= 8'd223) begin
         r = 11'd255;
         g = 11'd892 - v4;
      end else begin
         r = 11'd1147 - v4;
      end
      if (stg_invalid_ff[STEPS]) begin
         r = '0;
         g = '0;
         b = '0;
      end
      red_in   = r[COLOR_W-1:0];
      green_in = g[COLOR_W-1:0];
      blue_in  = b[COLOR_W-1:0];
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= stg_valid_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

endmodule

`default_nettype wire

// File: rtl/core/depth_to_jet_color_core.sv
// top level of the depth to jet color core: settings, front, queue and back
`default_nettype none

// Maps one 16-bit raw depth request to a jet false-color pixel. A zero sample
// gives black; otherwise depth in mm is raw times depth_scale (Q8.16), offset by
// depth_min_mm and scaled so that the span up to depth_max_mm (1000 mm when not
// positive) covers levels 0..255. The core takes one request per clock while
// req_stall is low and returns one pixel per clock while rsp_stall is low. A
// request passes three front stages, one queue slot, the back entry stage,
// eight divider stages at one quotient bit a stage and the response register.
// Requests wait in an 8-entry queue, so the front keeps accepting while the
// response side stalls until queue and front hold eight. Settings must be
// written only while idle; the user must ensure this, the core does not.

module depth_to_jet_color_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [djc_pkg::RAW_W-1:0]          req_depth_raw,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [djc_pkg::COLOR_W-1:0]             rsp_red,
   output logic [djc_pkg::COLOR_W-1:0]             rsp_green,
   output logic [djc_pkg::COLOR_W-1:0]             rsp_blue,
   input  wire logic                               csr_write_enable,
   input  wire logic [djc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [djc_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import djc_pkg::*;

   logic [SCALE_W-1:0]  depth_scale_ff;
   logic [MM_W-1:0]     depth_min_ff;
   logic [MM_W-1:0]     depth_max_ff;
   logic [MM_W-1:0]     span_ff;
   logic [MM_W-1:0]     span_in;

   front_cfg_type       front_cfg;
   logic                accept;
   logic                push;
   item_type            push_item;
   logic [BUSY_W-1:0]   busy;
   logic                pop;
   item_type            head_item;
   logic                head_valid;
   logic [QUEUE_CW-1:0] count;
   logic [QUEUE_CW:0]   reserved;

   // settings registers
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_scale_ff <= DEPTH_SCALE_RESET;
         depth_min_ff   <= DEPTH_MIN_RESET;
         depth_max_ff   <= DEPTH_MAX_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEPTH_SCALE:  depth_scale_ff <= csr_write_data[SCALE_W-1:0];
            CSR_DEPTH_MIN_MM: depth_min_ff   <= csr_write_data[MM_W-1:0];
            CSR_DEPTH_MAX_MM: depth_max_ff   <= csr_write_data[MM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // span with fallback
   assign span_in = (depth_max_ff > depth_min_ff) ? (depth_max_ff - depth_min_ff)
                                                  : FALLBACK_SPAN_MM;

   always_ff @(posedge clock) begin
      span_ff <= span_in;
   end

   // stall once the queue could not absorb what the front holds
   assign reserved  = {1'b0, count} + (QUEUE_CW+1)'(busy);
   assign req_stall = (reserved >= (QUEUE_CW+1)'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   assign front_cfg.depth_scale  = depth_scale_ff;
   assign front_cfg.depth_min_mm = depth_min_ff;

   djc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .depth_raw (req_depth_raw),
      .cfg       (front_cfg),
      .push      (push),
      .push_item (push_item),
      .busy      (busy)
   );

   djc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .head_item  (head_item),
      .head_valid (head_valid),
      .count      (count)
   );

   djc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .span       (span_ff),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_red    (rsp_red),
      .rsp_green  (rsp_green),
      .rsp_blue   (rsp_blue)
   );

endmodule

`default_nettype wire
